// ===== sv/multi_timer_scheduler_assert.svh =====
// assertion macros for the multi-timer scheduler
// used by the checker file only
`ifndef MULTI_TIMER_SCHEDULER_ASSERT_SVH
`define MULTI_TIMER_SCHEDULER_ASSERT_SVH
// clocked implication with reset disable
`define MTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mts check failed");
// next-cycle implication
`define MTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mts check failed");
`endif

// ===== sv/mts_pkg.sv =====
// package for the multi-timer scheduler: action codes, period kinds, config defaults and indices, states
// no dependencies
package mts_pkg;
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_ADD     = 3'd1;
    localparam logic [2:0] ACT_CANCEL  = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_REMOVE  = 3'd4;

    localparam logic [1:0] KIND_CUSTOM = 2'd0;
    localparam logic [1:0] KIND_DAY    = 2'd1;
    localparam logic [1:0] KIND_WEEK   = 2'd2;

    localparam logic [31:0] TICKS_PER_DAY_RESET = 32'd86400;
    localparam logic [31:0] MAX_WAIT_RESET      = 32'd1000;
    localparam logic [2:0]  DAYS_PER_WEEK       = 3'd7;

    localparam logic CFG_TICKS_PER_DAY = 1'b0;
    localparam logic CFG_MAX_WAIT      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_SLOT_RD,
        ST_SLOT_WR,
        ST_SCAN,
        ST_OUT
    } state_t;
endpackage

// ===== sv/multi_timer_scheduler.sv =====
// multi-timer scheduler top level: timer table, action sequencer, deadline scan
// depends on mts_pkg and mts_ram
//
// usage:
//  - input channel (valid/stall) carries one action item: tick, add, cancel,
//    restart or remove, with slot, period_mode, duration and repeat_limit
//  - output channel (valid/stall) returns one result item per action:
//    fired, fired_slot, finished, next_deadline and bad_slot
//  - config port (cfg_we, cfg_index, cfg_data) writes ticks_per_day and max_wait;
//    the user must write them only while the block is idle; the block does not enforce it
//  - trigger times sit in one synchronous ram, per-slot parameters in a second
//    ram; the open and used flags are flip-flops cleared by reset
//  - the earliest-trigger scan reads one slot per cycle
//  - a tick scans for the earliest trigger and, if it fires, reads and writes
//    that slot and rescans; add/cancel/restart/remove read and write the slot
//    and then scan; other codes only scan
//  - one item in work at a time; the next one can be taken in the cycle the result appears
//  - a stalled result waits in the output register with input stall high; a new
//    item is taken at the earliest in the cycle the held result is taken
//  - reset clears the time counter, all flags and sets the config defaults
module multi_timer_scheduler #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            action,
    input  logic [3:0]            slot,
    input  logic [1:0]            period_mode,
    input  logic [31:0]           duration,
    input  logic [31:0]           repeat_limit,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  fired,
    output logic [3:0]            fired_slot,
    output logic                  finished,
    output logic [TIME_WIDTH-1:0] next_deadline,
    output logic                  bad_slot
);
    import mts_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = SW + 1;
    localparam int PW = 32 + 32 + 32 + 2; // fire, limit, period, kind
    localparam logic [CW-1:0] SLOT_END = CW'(SLOT_COUNT);
    localparam int CAPW = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
    localparam logic [CAPW-1:0] TIME_TOP = CAPW'({TIME_WIDTH{1'b1}});

    // config registers
    logic [31:0] tpd_reg, mw_reg;

    // state machine and item registers
    state_t state_reg, state_next;
    logic [2:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [1:0]  mode_reg;
    logic [31:0] dur_reg, lim_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic [SLOT_COUNT-1:0] used_reg, open_reg;

    // scan state
    logic [CW-1:0] scan_idx_reg;     // address issued
    logic          scan_rv_reg;      // read data valid
    logic [SW-1:0] scan_rslot_reg;   // slot of the read data
    logic          best_v_reg;
    logic [SW-1:0] best_s_reg;
    logic [TIME_WIDTH-1:0] best_t_reg;

    // result registers
    logic ov_reg, f_reg, fin_reg, bad_reg;
    logic [3:0] fs_reg;
    logic [TIME_WIDTH-1:0] nd_reg;

    // ram ports
    logic                  t_we, p_we;
    logic [SW-1:0]         t_waddr, t_raddr, p_addr;
    logic [TIME_WIDTH-1:0] t_wdata, t_rdata;
    logic [PW-1:0]         p_wdata, p_rdata;

    mts_ram #(.WIDTH(TIME_WIDTH), .DEPTH(SLOT_COUNT)) u_trig (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    mts_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_par (
        .clk(clk), .we(p_we), .waddr(p_addr), .wdata(p_wdata),
        .raddr(p_addr), .rdata(p_rdata)
    );

    // unpacked parameter read
    logic [31:0] rd_fire, rd_lim, rd_per;
    logic [1:0]  rd_kind;
    assign {rd_fire, rd_lim, rd_per, rd_kind} = p_rdata;

    // week period needs a 35-bit product; registered on config write
    logic [34:0] week_reg;

    function automatic logic [34:0] period_f(input logic [1:0] k, input logic [31:0] p,
                                             input logic [31:0] tpd,
                                             input logic [34:0] wk);
        logic [34:0] r;
        begin
            case (k)
                KIND_DAY:  r = {3'b0, tpd};
                KIND_WEEK: r = wk;
                default:   r = {3'b0, p};
            endcase
            return r;
        end
    endfunction

    logic in_ok, slot_ok, hold;
    logic [SW-1:0] s_idx;
    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign in_ok    = in_valid && !in_stall;
    assign slot_ok  = (32'(slot_reg) < 32'(SLOT_COUNT));
    assign s_idx    = SW'(slot_reg);
    assign hold     = ov_reg && out_stall;

    // cap = min(now + max_wait, all ones)
    logic [CAPW-1:0] cap_sum;
    logic [TIME_WIDTH-1:0] cap;
    assign cap_sum = CAPW'(now_reg) + CAPW'(mw_reg);
    assign cap = (cap_sum > TIME_TOP) ? '1 : cap_sum[TIME_WIDTH-1:0];

    // fire decision and new trigger
    logic fire_due, lim_hit;
    logic [TIME_WIDTH-1:0] t_adv, t_arm;
    assign fire_due = best_v_reg && (best_t_reg <= now_reg);
    assign lim_hit  = (rd_lim != 32'd0) && (rd_lim == rd_fire);
    assign t_adv = best_t_reg + TIME_WIDTH'(period_f(rd_kind, rd_per, tpd_reg, week_reg));

    logic [1:0] add_kind;
    assign add_kind = (mode_reg == 2'd3) ? KIND_CUSTOM : mode_reg;

    always_comb
    begin
        state_next = state_reg;
        t_we = 1'b0; p_we = 1'b0;
        t_waddr = s_idx; t_wdata = '0; p_wdata = p_rdata;
        t_raddr = scan_idx_reg[SW-1:0];
        p_addr  = s_idx;
        t_arm   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ok)
                begin
                    if (action == ACT_TICK)
                        state_next = ST_TICK_SCAN;
                    else if (action inside {ACT_ADD, ACT_CANCEL, ACT_RESTART, ACT_REMOVE})
                        state_next = ST_SLOT_RD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_TICK_SCAN:
            begin
                if (scan_idx_reg == SLOT_END && !scan_rv_reg)
                    state_next = fire_due ? ST_TICK_RD : ST_SCAN;
            end
            ST_TICK_RD:
            begin
                p_addr = best_s_reg;
                state_next = ST_TICK_WR;
            end
            ST_TICK_WR:
            begin
                p_addr = best_s_reg;
                t_waddr = best_s_reg;
                if (!lim_hit)
                begin
                    t_we = 1'b1; p_we = 1'b1;
                    t_wdata = t_adv;
                    p_wdata = {rd_fire + 32'd1, rd_lim, rd_per, rd_kind};
                end
                state_next = ST_SCAN;
            end
            ST_SLOT_RD:
            begin
                state_next = ST_SLOT_WR;
            end
            ST_SLOT_WR:
            begin
                if (slot_ok)
                begin
                    if (act_reg == ACT_ADD && !used_reg[s_idx])
                    begin
                        t_arm = now_reg + TIME_WIDTH'(period_f(add_kind, dur_reg,
                                                               tpd_reg, week_reg));
                        t_we = 1'b1; p_we = 1'b1;
                        t_wdata = t_arm;
                        p_wdata = {32'd1, lim_reg, dur_reg, add_kind};
                    end
                    else if (act_reg == ACT_RESTART && used_reg[s_idx])
                    begin
                        t_arm = now_reg + TIME_WIDTH'(period_f(rd_kind, rd_per,
                                                               tpd_reg, week_reg));
                        t_we = 1'b1; p_we = 1'b1;
                        t_wdata = t_arm;
                        p_wdata = {32'd1, rd_lim, rd_per, rd_kind};
                    end
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SLOT_END && !scan_rv_reg)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!hold)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic scanning;
    assign scanning = (state_reg == ST_TICK_SCAN) || (state_reg == ST_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tpd_reg <= TICKS_PER_DAY_RESET;
            mw_reg <= MAX_WAIT_RESET;
            week_reg <= 35'(TICKS_PER_DAY_RESET) * 35'(DAYS_PER_WEEK);
            now_reg <= '0;
            used_reg <= '0;
            open_reg <= '0;
            ov_reg <= 1'b0;
            f_reg <= 1'b0;
            fin_reg <= 1'b0;
            bad_reg <= 1'b0;
            fs_reg <= '0;
            nd_reg <= '0;
            scan_idx_reg <= '0;
            scan_rv_reg <= 1'b0;
            scan_rslot_reg <= '0;
            best_v_reg <= 1'b0;
            best_s_reg <= '0;
            best_t_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TICKS_PER_DAY)
                begin
                    tpd_reg <= cfg_data;
                    week_reg <= {3'b0, cfg_data} * 35'(DAYS_PER_WEEK);
                end
                else
                    mw_reg <= cfg_data;
            end
            if (ov_reg && !out_stall && state_reg != ST_OUT)
                ov_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    scan_idx_reg <= '0;
                    scan_rv_reg <= 1'b0;
                    best_v_reg <= 1'b0;
                    if (in_ok)
                    begin
                        f_reg <= 1'b0; fin_reg <= 1'b0; fs_reg <= '0; bad_reg <= 1'b0;
                        if (action == ACT_TICK)
                            now_reg <= now_reg + TIME_WIDTH'(1);
                    end
                end
                ST_TICK_WR:
                begin
                    f_reg <= 1'b1;
                    fs_reg <= 4'(best_s_reg);
                    if (lim_hit)
                    begin
                        open_reg[best_s_reg] <= 1'b0;
                        fin_reg <= 1'b1;
                    end
                end
                ST_SLOT_WR:
                begin
                    if (!slot_ok)
                        bad_reg <= 1'b1;
                    else if (act_reg == ACT_ADD)
                    begin
                        if (used_reg[s_idx])
                            bad_reg <= 1'b1;
                        else
                        begin
                            used_reg[s_idx] <= 1'b1;
                            open_reg[s_idx] <= 1'b1;
                        end
                    end
                    else if (!used_reg[s_idx])
                        bad_reg <= 1'b1;
                    else if (act_reg == ACT_CANCEL)
                        open_reg[s_idx] <= 1'b0;
                    else if (act_reg == ACT_RESTART)
                        open_reg[s_idx] <= 1'b1;
                    else
                    begin
                        used_reg[s_idx] <= 1'b0;
                        open_reg[s_idx] <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (!hold)
                    begin
                        ov_reg <= 1'b1;
                        nd_reg <= (best_v_reg && best_t_reg < cap) ? best_t_reg : cap;
                    end
                end
                default: ;
            endcase

            // shared scan: issue one read per cycle, compare the returned one
            if (scanning)
            begin
                if (scan_idx_reg != SLOT_END)
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                scan_rv_reg <= (scan_idx_reg != SLOT_END);
                scan_rslot_reg <= scan_idx_reg[SW-1:0];
                if (scan_rv_reg && open_reg[scan_rslot_reg] &&
                    (!best_v_reg || t_rdata < best_t_reg))
                begin
                    best_v_reg <= 1'b1;
                    best_s_reg <= scan_rslot_reg;
                    best_t_reg <= t_rdata;
                end
            end
            else if (state_reg != ST_IDLE)
            begin
                scan_idx_reg <= '0;
                scan_rv_reg <= 1'b0;
                if (state_reg != ST_OUT)
                    best_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ok)
        begin
            act_reg <= action;
            slot_reg <= slot;
            mode_reg <= period_mode;
            dur_reg <= duration;
            lim_reg <= repeat_limit;
        end
    end

    assign out_valid     = ov_reg;
    assign fired         = f_reg;
    assign fired_slot    = fs_reg;
    assign finished      = fin_reg;
    assign next_deadline = nd_reg;
    assign bad_slot      = bad_reg;
endmodule

// ===== sv/mts_ram.sv =====
// generic single-port-write, single-read synchronous ram with registered read
// no dependencies
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/mts_checker.sv =====
// port-level checker for the multi-timer scheduler, bound to the top level
// depends on multi_timer_scheduler_assert.svh
`include "multi_timer_scheduler_assert.svh"
module mts_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic fired,
    input logic finished,
    input logic bad_slot
);
    // a held result stays held while stalled
    `MTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // finished only with fired
    `MTS_ASSERT_IMP(a_fin_fired, clk, rst_n, out_valid && finished, fired)
    // a firing tick never reports a bad slot
    `MTS_ASSERT_IMP(a_fire_bad, clk, rst_n, out_valid && fired, !bad_slot)
    // after an accepted item the block is busy
    `MTS_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind multi_timer_scheduler mts_port_checker u_mts_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .fired(fired),
    .finished(finished), .bad_slot(bad_slot)
);

// ===== test/mts_checker.sv =====
// checker for the multi-timer scheduler: watches the action and result channels,
// predicts each result from its own copy of the timer table, and counts mismatches
// depends on mts_pkg
`timescale 1ns / 100ps
module mts_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  slot,
    input  logic [1:0]  period_mode,
    input  logic [31:0] duration,
    input  logic [31:0] repeat_limit,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        fired,
    input  logic [3:0]  fired_slot,
    input  logic        finished,
    input  logic [47:0] next_deadline,
    input  logic        bad_slot,
    output int          fail_count,
    output int          pending_count
);
    import mts_pkg::*;

    typedef struct packed {
        logic        fired;
        logic [3:0]  fired_slot;
        logic        finished;
        logic [47:0] next_deadline;
        logic        bad_slot;
    } timer_result_t;

    localparam logic [47:0] TIME_MAX = '1;

    logic [31:0] day_ticks;
    logic [31:0] wait_cap;
    logic [47:0] clock_now;
    logic [47:0] due_at [16];
    logic [31:0] fires [16];
    logic [31:0] limits [16];
    logic [31:0] custom_len [16];
    logic [1:0]  kinds [16];
    logic        used [16];
    logic        open [16];
    timer_result_t expected_results [$];

    function automatic logic [47:0] period_len(int s);
        if (kinds[s] == KIND_DAY)
            return {16'd0, day_ticks};
        if (kinds[s] == KIND_WEEK)
            return 48'(day_ticks) * 48'd7;
        return {16'd0, custom_len[s]};
    endfunction

    function automatic int soonest_slot();
        int best;
        best = -1;
        for (int i = 0; i < 16; i++)
            if (open[i] && (best < 0 || due_at[i] < due_at[best]))
                best = i;
        return best;
    endfunction

    task automatic rearm(int s);
        fires[s] = 1;
        due_at[s] = clock_now + period_len(s);
        open[s] = 1'b1;
    endtask

    // apply one action to the table and return the result it must produce
    task automatic schedule_action(input logic [2:0] act, input logic [3:0] s,
                                   input logic [1:0] mode, input logic [31:0] dur,
                                   input logic [31:0] lim, output timer_result_t r);
        int e;
        logic [48:0] cap;
        r = '0;
        if (act == ACT_TICK) begin
            clock_now = clock_now + 48'd1;
            e = soonest_slot();
            if (e >= 0 && due_at[e] <= clock_now) begin
                r.fired = 1'b1;
                r.fired_slot = 4'(e);
                if (limits[e] != 0 && limits[e] == fires[e]) begin
                    open[e] = 1'b0;
                    r.finished = 1'b1;
                end else begin
                    fires[e] = fires[e] + 32'd1;
                    due_at[e] = due_at[e] + period_len(e);
                end
            end
        end else if (act == ACT_ADD) begin
            if (used[s])
                r.bad_slot = 1'b1;
            else begin
                used[s] = 1'b1;
                kinds[s] = (mode == 2'd3) ? KIND_CUSTOM : mode;
                custom_len[s] = dur;
                limits[s] = lim;
                rearm(s);
            end
        end else if (act == ACT_CANCEL || act == ACT_RESTART || act == ACT_REMOVE) begin
            if (!used[s])
                r.bad_slot = 1'b1;
            else if (act == ACT_CANCEL)
                open[s] = 1'b0;
            else if (act == ACT_RESTART)
                rearm(s);
            else begin
                used[s] = 1'b0;
                open[s] = 1'b0;
            end
        end
        // deadline: earliest open trigger, capped with saturation
        cap = {1'b0, clock_now} + 49'(wait_cap);
        r.next_deadline = cap[48] ? TIME_MAX : cap[47:0];
        e = soonest_slot();
        if (e >= 0 && due_at[e] < r.next_deadline)
            r.next_deadline = due_at[e];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t exp_r;
        timer_result_t got_r;
        if (!rst_n) begin
            day_ticks <= TICKS_PER_DAY_RESET;
            wait_cap <= MAX_WAIT_RESET;
            clock_now = '0;
            for (int i = 0; i < 16; i++) begin
                due_at[i] = '0;
                fires[i] = '0;
                limits[i] = '0;
                custom_len[i] = '0;
                kinds[i] = KIND_CUSTOM;
                used[i] = 1'b0;
                open[i] = 1'b0;
            end
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TICKS_PER_DAY)
                    day_ticks <= cfg_data;
                else
                    wait_cap <= cfg_data;
            end
            if (in_valid && !in_stall) begin
                schedule_action(action, slot, period_mode, duration, repeat_limit, exp_r);
                expected_results.push_back(exp_r);
            end
            if (out_valid && !out_stall) begin
                got_r = '{fired, fired_slot, finished, next_deadline, bad_slot};
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result item %p", got_r);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %p actual %p", exp_r, got_r);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

// ===== test/tb.sv =====
// testbench top for the multi-timer scheduler: clock, reset, config writes and
// action stimulus with random idling; depends on mts_pkg, mts_checker and the block
`timescale 1ns / 100ps
module tb;
    import mts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_TICK;
    logic [3:0]  slot = '0;
    logic [1:0]  period_mode = KIND_CUSTOM;
    logic [31:0] duration = '0;
    logic [31:0] repeat_limit = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        fired;
    logic [3:0]  fired_slot;
    logic        finished;
    logic [47:0] next_deadline;
    logic        bad_slot;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    // when set, neither side idles
    bit          steady = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    always #1 clk = ~clk;

    multi_timer_scheduler DUT (.*);

    mts_checker checker_i (.*);

    // receiver stall, random except during the steady stretch
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 28);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_timer_scheduler regression: fail");
            $finish;
        end
    end

    // present one action item and hold it until accepted; valid drops only
    // when the sender idles or drains
    task automatic send_action(input logic [2:0] a, input logic [3:0] s,
                               input logic [1:0] m, input logic [31:0] d,
                               input logic [31:0] l);
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        slot <= s;
        period_mode <= m;
        duration <= d;
        repeat_limit <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drain all results, then let the block settle before a config write
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random action: mostly ticks and short durations so firings happen
    task automatic random_action(input logic [31:0] dur_hi);
        logic [2:0]  a;
        logic [31:0] d;
        logic [31:0] l;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 55)
            a = ACT_TICK;
        else if (pick < 75)
            a = ACT_ADD;
        else if (pick < 83)
            a = ACT_CANCEL;
        else if (pick < 90)
            a = ACT_RESTART;
        else if (pick < 97)
            a = ACT_REMOVE;
        else
            a = 3'($urandom_range(7, 5));
        d = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(dur_hi);
        l = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(4);
        send_action(a, 4'($urandom_range(15)), 2'($urandom_range(3)), d, l);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every action, bad slots, zero duration
        send_action(ACT_CANCEL, 4'd3, KIND_CUSTOM, 32'd5, 32'd0);
        send_action(ACT_ADD, 4'd0, KIND_CUSTOM, 32'd0, 32'd2);
        send_action(ACT_ADD, 4'd0, KIND_CUSTOM, 32'd4, 32'd0);
        send_action(ACT_ADD, 4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_action(ACT_ADD, 4'd7, KIND_DAY, 32'd1, 32'd1);
        send_action(ACT_ADD, 4'd8, KIND_WEEK, 32'd1, 32'd0);
        send_action(ACT_ADD, 4'd1, KIND_CUSTOM, 32'd3, 32'd1);
        repeat (4) send_action(ACT_TICK, 4'd0, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(ACT_RESTART, 4'd1, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(ACT_CANCEL, 4'd15, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(ACT_REMOVE, 4'd8, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(ACT_REMOVE, 4'd8, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(ACT_RESTART, 4'd9, KIND_CUSTOM, 32'd0, 32'd0);
        send_action(3'd7, 4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_action(3'd5, 4'd0, KIND_CUSTOM, 32'd0, 32'd0);
        repeat (3) send_action(ACT_TICK, 4'd0, KIND_CUSTOM, 32'd0, 32'd0);
        drain();

        // phases over several register settings, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            logic [31:0] tpd;
            logic [31:0] mw;
            case (phase)
                0: begin tpd = 32'd1; mw = 32'd1; end
                1: begin tpd = 32'hFFFF_FFFF; mw = 32'hFFFF_FFFF; end
                2: begin tpd = 32'd5; mw = 32'd3; end
                3: begin tpd = $urandom_range(30, 1); mw = $urandom_range(50, 1); end
                4: begin tpd = $urandom(); mw = $urandom(); end
                default: begin tpd = 32'd86400; mw = 32'd1000; end
            endcase
            write_reg(CFG_TICKS_PER_DAY, tpd);
            write_reg(CFG_MAX_WAIT, mw);
            steady = (phase == 2);
            for (int n = 0; n < 290; n++)
                random_action((phase == 1) ? 32'hFFFF_FFFF : 32'd12);
            drain();
        end
        steady = 1'b0;

        if (fail_count == 0)
            $display("multi_timer_scheduler regression: pass");
        else
            $display("multi_timer_scheduler regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/mts_pkg.sv
sv/mts_ram.sv
sv/multi_timer_scheduler.sv
sv/mts_checker.sv
test/mts_checker.sv
test/tb.sv
